// File: src/ttf_pkg.sv
`default_nettype none
package ttf_pkg;

  localparam int unsigned POS_W = 24;
  localparam int unsigned TEX_W = 16;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned VEC_W = 44;
  localparam int unsigned EDG_W = 25;
  localparam int unsigned DLT_W = 17;
  localparam int unsigned TRM_W = 52;
  localparam int unsigned MAG_W = 51;
  localparam int unsigned OPK_W = 5;
  localparam int unsigned IN_DW = 104;
  localparam int unsigned OUT_DW = 312;
  localparam logic [DLT_W-1:0] ONE_Q12 = DLT_W'(4096);

  // micro-op indexes for the shared multiplier
  localparam logic [OPK_W-1:0] K_CROSS0 = 5'd0;
  localparam logic [OPK_W-1:0] K_TEXEND = 5'd9;
  localparam logic [OPK_W-1:0] K_VECBEG = 5'd10;
  localparam logic [OPK_W-1:0] K_VECEND = 5'd21;
  localparam logic [OPK_W-1:0] K_SQBEG = 5'd22;
  localparam logic [OPK_W-1:0] K_SQEND = 5'd24;

  // stored term slots
  localparam int unsigned T_DIR = 3;
  localparam int unsigned T_DEG = 4;
  localparam int unsigned T_TAN = 5;
  localparam int unsigned T_BIT = 8;
  localparam int unsigned N_TRM = 11;

  typedef enum logic [3:0] {
    OPD_V0, OPD_V1, OPD_V2, OPD_W0, OPD_W1, OPD_W2,
    OPD_SX, OPD_SY, OPD_TX, OPD_TY, OPD_M0, OPD_M1, OPD_M2
  } opnd_t;

  typedef struct packed {
    logic             store0;
    logic             store1;
    logic             store2;
    logic             edge_en;
    logic             mul_en;
    logic [OPK_W-1:0] mul_k;
    logic             fix;
    logic             load_mag;
    logic             shift;
    logic             clr_norm;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             div_first;
    logic             div_last;
    logic [1:0]       div_idx;
    logic             load_out;
  } ttf_cmd_t;

  typedef struct packed {
    logic mag_big;
    logic mag_zero;
  } ttf_sts_t;

  function automatic opnd_t op_a(input logic [OPK_W-1:0] k);
    opnd_t r;
    unique case (k)
      5'd0: r = OPD_V1;  5'd1: r = OPD_V2;  5'd2: r = OPD_V2;  5'd3: r = OPD_V0;
      5'd4: r = OPD_V0;  5'd5: r = OPD_V1;  5'd6: r = OPD_TX;  5'd7: r = OPD_TY;
      5'd8: r = OPD_SX;  5'd9: r = OPD_SY;  5'd10: r = OPD_W0; 5'd11: r = OPD_V0;
      5'd12: r = OPD_W1; 5'd13: r = OPD_V1; 5'd14: r = OPD_W2; 5'd15: r = OPD_V2;
      5'd16: r = OPD_V0; 5'd17: r = OPD_W0; 5'd18: r = OPD_V1; 5'd19: r = OPD_W1;
      5'd20: r = OPD_V2; 5'd21: r = OPD_W2; 5'd22: r = OPD_M0; 5'd23: r = OPD_M1;
      5'd24: r = OPD_M2;
      default: r = OPD_M0;
    endcase
    return r;
  endfunction

  function automatic opnd_t op_b(input logic [OPK_W-1:0] k);
    opnd_t r;
    unique case (k)
      5'd0: r = OPD_W2;  5'd1: r = OPD_W1;  5'd2: r = OPD_W0;  5'd3: r = OPD_W2;
      5'd4: r = OPD_W1;  5'd5: r = OPD_W0;  5'd6: r = OPD_SY;  5'd7: r = OPD_SX;
      5'd8: r = OPD_TY;  5'd9: r = OPD_TX;  5'd10: r = OPD_SY; 5'd11: r = OPD_TY;
      5'd12: r = OPD_SY; 5'd13: r = OPD_TY; 5'd14: r = OPD_SY; 5'd15: r = OPD_TY;
      5'd16: r = OPD_TX; 5'd17: r = OPD_SX; 5'd18: r = OPD_TX; 5'd19: r = OPD_SX;
      5'd20: r = OPD_TX; 5'd21: r = OPD_SX; 5'd22: r = OPD_M0; 5'd23: r = OPD_M1;
      5'd24: r = OPD_M2;
      default: r = OPD_M0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/ttf_dp.sv
`default_nettype none
module ttf_dp (
  input  wire logic                       clk,
  input  wire ttf_pkg::ttf_cmd_t          cmd,
  output ttf_pkg::ttf_sts_t               sts,
  input  wire logic [ttf_pkg::IN_DW-1:0]  in_data,
  output logic      [ttf_pkg::OUT_DW-1:0] out_data
);

  logic signed [23:0] p0_r [3];
  logic signed [23:0] p1_r [3];
  logic signed [23:0] p2_r [3];
  logic signed [15:0] t0_r [2];
  logic signed [15:0] t1_r [2];
  logic signed [15:0] t2_r [2];
  logic signed [24:0] v_r [3];
  logic signed [24:0] w_r [3];
  logic signed [16:0] sx_r, sy_r, tx_r, ty_r;
  logic signed [63:0] prod_r;
  logic               pv_r;
  logic [4:0]         kd_r;
  logic signed [51:0] acc_r;
  logic signed [51:0] term_r [ttf_pkg::N_TRM];
  logic               dir_neg_r;
  logic [50:0]        mag_r [3];
  logic               neg_r [3];
  logic [63:0]        sum_r;
  logic [63:0]        num_r, res_r, bit_r;
  logic [32:0]        rem_r;
  logic [14:0]        q_r;
  logic signed [15:0] n_r [3];
  logic [ttf_pkg::OUT_DW-1:0] out_r;

  logic signed [31:0] opa, opb;
  logic [63:0]        rb;
  logic [32:0]        dt;
  logic               dge;
  logic [14:0]        q_nxt;
  logic [ttf_pkg::OUT_DW-1:0] out_nxt;
  logic signed [51:0] tv, bv;

  function automatic logic signed [31:0] pick(input ttf_pkg::opnd_t c,
      input logic signed [24:0] v0, input logic signed [24:0] v1,
      input logic signed [24:0] v2, input logic signed [24:0] w0,
      input logic signed [24:0] w1, input logic signed [24:0] w2,
      input logic signed [16:0] sx, input logic signed [16:0] sy,
      input logic signed [16:0] tx, input logic signed [16:0] ty,
      input logic [30:0] m0, input logic [30:0] m1, input logic [30:0] m2);
    logic signed [31:0] r;
    unique case (c)
      ttf_pkg::OPD_V0: r = 32'(v0);
      ttf_pkg::OPD_V1: r = 32'(v1);
      ttf_pkg::OPD_V2: r = 32'(v2);
      ttf_pkg::OPD_W0: r = 32'(w0);
      ttf_pkg::OPD_W1: r = 32'(w1);
      ttf_pkg::OPD_W2: r = 32'(w2);
      ttf_pkg::OPD_SX: r = 32'(sx);
      ttf_pkg::OPD_SY: r = 32'(sy);
      ttf_pkg::OPD_TX: r = 32'(tx);
      ttf_pkg::OPD_TY: r = 32'(ty);
      ttf_pkg::OPD_M0: r = $signed({1'b0, m0});
      ttf_pkg::OPD_M1: r = $signed({1'b0, m1});
      ttf_pkg::OPD_M2: r = $signed({1'b0, m2});
      default:         r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(ttf_pkg::op_a(cmd.mul_k), v_r[0], v_r[1], v_r[2], w_r[0], w_r[1], w_r[2],
               sx_r, sy_r, tx_r, ty_r, mag_r[0][30:0], mag_r[1][30:0], mag_r[2][30:0]);
    opb = pick(ttf_pkg::op_b(cmd.mul_k), v_r[0], v_r[1], v_r[2], w_r[0], w_r[1], w_r[2],
               sx_r, sy_r, tx_r, ty_r, mag_r[0][30:0], mag_r[1][30:0], mag_r[2][30:0]);
    rb = res_r + bit_r;
    dt = {rem_r[31:0], cmd.div_first ? mag_r[cmd.div_idx][0] : 1'b0};
    dge = (dt >= {1'b0, res_r[31:0]});
    q_nxt = {q_r[13:0], dge};
    sts.mag_big = (|mag_r[0][50:31]) | (|mag_r[1][50:31]) | (|mag_r[2][50:31]);
    sts.mag_zero = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
    out_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      tv = dir_neg_r ? -term_r[ttf_pkg::T_TAN+i] : term_r[ttf_pkg::T_TAN+i];
      bv = dir_neg_r ? -term_r[ttf_pkg::T_BIT+i] : term_r[ttf_pkg::T_BIT+i];
      out_nxt[16*i +: 16] = n_r[i];
      out_nxt[48 + 44*i +: 44] = tv[43:0];
      out_nxt[180 + 44*i +: 44] = bv[43:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store0) begin
      for (int i = 0; i < 3; i++) p0_r[i] <= in_data[24*i +: 24];
      for (int i = 0; i < 2; i++) t0_r[i] <= in_data[72 + 16*i +: 16];
    end
    if (cmd.store1) begin
      for (int i = 0; i < 3; i++) p1_r[i] <= in_data[24*i +: 24];
      for (int i = 0; i < 2; i++) t1_r[i] <= in_data[72 + 16*i +: 16];
    end
    if (cmd.store2) begin
      for (int i = 0; i < 3; i++) p2_r[i] <= in_data[24*i +: 24];
      for (int i = 0; i < 2; i++) t2_r[i] <= in_data[72 + 16*i +: 16];
    end
    if (cmd.edge_en) begin
      for (int i = 0; i < 3; i++) begin
        v_r[i] <= 25'(p1_r[i]) - 25'(p0_r[i]);
        w_r[i] <= 25'(p2_r[i]) - 25'(p0_r[i]);
      end
      sx_r <= 17'(t1_r[0]) - 17'(t0_r[0]);
      sy_r <= 17'(t1_r[1]) - 17'(t0_r[1]);
      tx_r <= 17'(t2_r[0]) - 17'(t0_r[0]);
      ty_r <= 17'(t2_r[1]) - 17'(t0_r[1]);
    end
    // multiply, then fold pairs into a - b terms or squares into the sum
    pv_r <= cmd.mul_en;
    kd_r <= cmd.mul_k;
    if (cmd.mul_en) prod_r <= opa * opb;
    if (pv_r) begin
      if (kd_r >= ttf_pkg::K_SQBEG) begin
        sum_r <= (kd_r == ttf_pkg::K_SQBEG) ? prod_r : sum_r + prod_r;
      end else if (!kd_r[0]) begin
        acc_r <= prod_r[51:0];
      end else begin
        term_r[kd_r[4:1]] <= acc_r - $signed(prod_r[51:0]);
      end
    end
    if (cmd.fix) begin
      dir_neg_r <= term_r[ttf_pkg::T_DIR] < 0;
      if (term_r[ttf_pkg::T_DEG] == 0) begin
        sx_r <= '0;
        sy_r <= ttf_pkg::ONE_Q12;
        tx_r <= ttf_pkg::ONE_Q12;
        ty_r <= '0;
      end
    end
    if (cmd.load_mag) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= term_r[i][51];
        mag_r[i] <= term_r[i][51] ? 51'(-term_r[i]) : term_r[i][50:0];
      end
    end
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
    end
    if (cmd.clr_norm) begin
      for (int i = 0; i < 3; i++) n_r[i] <= '0;
    end
    if (cmd.sqrt_init) begin
      num_r <= sum_r;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end
    if (cmd.sqrt_step) begin
      if (num_r >= rb) begin
        num_r <= num_r - rb;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      rem_r <= {3'b0, mag_r[cmd.div_idx][30:1]};
      q_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= dge ? dt - {1'b0, res_r[31:0]} : dt;
      q_r <= q_nxt;
      if (cmd.div_last) begin
        n_r[cmd.div_idx] <= neg_r[cmd.div_idx] ? -$signed({1'b0, q_nxt})
                                               : $signed({1'b0, q_nxt});
      end
    end
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: src/ttf_ctrl.sv
`default_nettype none
module ttf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ttf_pkg::ttf_sts_t sts,
  output ttf_pkg::ttf_cmd_t      cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_EDGE  = 14'b00000000000010,
    S_MULA  = 14'b00000000000100,
    S_FLSA  = 14'b00000000001000,
    S_FIX   = 14'b00000000010000,
    S_MULB  = 14'b00000000100000,
    S_NORM  = 14'b00000001000000,
    S_SHIFT = 14'b00000010000000,
    S_SQ    = 14'b00000100000000,
    S_FLSQ  = 14'b00001000000000,
    S_SQI   = 14'b00010000000000,
    S_SQRT  = 14'b00100000000000,
    S_DIV   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.mul_k = cnt_r;
    cmd.div_idx = idx_r;
    acc = in_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority case (phase_r)
            2'd1: begin
              cmd.store1 = 1'b1;
              phase_nxt = 2'd2;
            end
            2'd2: begin
              cmd.store2 = 1'b1;
              phase_nxt = 2'd0;
              state_nxt = S_EDGE;
            end
            default: begin
              cmd.store0 = 1'b1;
              phase_nxt = 2'd1;
            end
          endcase
        end
      end
      S_EDGE: begin
        cmd.edge_en = 1'b1;
        cnt_nxt = ttf_pkg::K_CROSS0;
        state_nxt = S_MULA;
      end
      S_MULA: begin
        cmd.mul_en = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == ttf_pkg::K_TEXEND) state_nxt = S_FLSA;
      end
      S_FLSA: state_nxt = S_FIX;
      S_FIX: begin
        cmd.fix = 1'b1;
        cnt_nxt = ttf_pkg::K_VECBEG;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_en = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == ttf_pkg::K_VECEND) state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.load_mag = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        priority if (sts.mag_zero) begin
          cmd.clr_norm = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.mag_big) begin
          cmd.shift = 1'b1;
        end else begin
          cnt_nxt = ttf_pkg::K_SQBEG;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == ttf_pkg::K_SQEND) state_nxt = S_FLSQ;
      end
      S_FLSQ: state_nxt = S_SQI;
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          // seed the divide of the first component
          cmd.div_init = 1'b1;
          cmd.div_idx = 2'd0;
          idx_nxt = 2'd0;
          cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == 5'd15) begin
          // seed the divide of the next component
          cmd.div_init = 1'b1;
          cnt_nxt = '0;
        end else begin
          cmd.div_step = 1'b1;
          cmd.div_first = (cnt_r == 5'd0);
          cmd.div_last = (cnt_r == 5'd14);
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd14) begin
            if (idx_r == 2'd2) begin
              cnt_nxt = '0;
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ov_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;

endmodule
`default_nettype wire

// File: src/triangle_tangent_frame_core.sv
`default_nettype none
// Per-triangle normal, tangent and bitangent for a triangle list.
// Input channel in_*: one vertex per beat; in_tdata holds, lowest bit first,
//   pos_x[23:0] pos_y[47:24] pos_z[71:48] (Q12.12), tex_u[87:72] tex_v[103:88] (Q4.12).
// Output channel out_*: one beat per triangle, after every third vertex;
//   out_tdata holds normal_x/y/z (16 bits each, Q1.14) from bit 0, then
//   tangent_x/y/z and bitangent_x/y/z (44 bits each, 24 fraction bits).
// Sequence: the first two vertices of a triangle are each stored as they are
//   accepted. The third runs a sequencer over one shared 32x32 multiplier (25
//   products), a normalizing right shift of up to 20 bits, a 32-step square root
//   and three 15-step divides, each divide after the first seeded in its own cycle.
// in_tready stays low from the third vertex until the result is loaded into the
//   output register, so a triangle's vertices wait for the previous result.
//   A zero-area triangle skips root and divides and reports a zero normal.
// The result sits in an output register; the block takes further vertices
//   while it waits. A finished result that finds the register still full holds
//   in_tready low until the receiver takes the pending beat with out_tready.
// Reset (rst_n low, synchronous) restarts the vertex count at the first
//   vertex of a triangle and drops any pending result.
module triangle_tangent_frame_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [311:0] out_tdata   // normal_x/y/z, tangent_x/y/z, bitangent_x/y/z
);

  ttf_pkg::ttf_cmd_t cmd;
  ttf_pkg::ttf_sts_t sts;

  ttf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttf_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

endmodule
`default_nettype wire
